[design/qps_pkg.sv]
package qps_pkg;

  localparam int SCOPE_DEPTH      = 1024 * 16;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int ADDR_W           = $clog2(SCOPE_DEPTH);
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);

  localparam int PHASE_W = 32;
  localparam int ACC_W   = 32;

  localparam logic [31:0] PROBE_STEP_RESET = 32'd993394;
  localparam logic [15:0] FALLOFF_RESET    = 16'd66;
  localparam logic [14:0] TRIG_PEAK        = 15'd32767;

  localparam longint Q30_ONE   = 64'sd1073741824;
  localparam longint TAYLOR_C1 = 64'sd1686629713;
  localparam longint TAYLOR_C3 = -64'sd693598669;
  localparam longint TAYLOR_C5 = 64'sd85569306;
  localparam longint TAYLOR_C7 = -64'sd5026995;
  localparam longint TAYLOR_C9 = 64'sd172272;
  localparam longint HALF_LSB  = 64'sd16384;
  localparam longint Q15_SCALE = 64'sd32768;
  localparam longint Q15_MAX   = 64'sd32767;

  typedef logic               command_t;
  typedef logic signed [15:0] sample_t;
  typedef logic [13:0]        index_t;
  typedef logic signed [15:0] probe_t;
  typedef logic [15:0]        phase_out_t;
  typedef logic [0:0]         cfg_index_t;
  typedef logic [31:0]        cfg_data_t;

  localparam command_t CMD_PROCESS = 1'b0;
  localparam command_t CMD_READ    = 1'b1;

  localparam cfg_index_t CFG_PROBE_STEP = 1'b0;
  localparam cfg_index_t CFG_FALLOFF    = 1'b1;

  typedef struct packed {
    logic take;
    logic advance;
    logic multiply;
    logic integrate;
    logic load;
  } qps_cmd_t;

  typedef logic [14:0] qtab_t [SINE_TABLE_DEPTH];

  function automatic qtab_t build_quarter_table();
    qtab_t  tab;
    longint t;
    longint t2;
    longint p;
    longint v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      t  = (longint'(i) * Q30_ONE) / SINE_TABLE_DEPTH;
      t2 = (t * t) / Q30_ONE;
      p  = TAYLOR_C9;
      p  = TAYLOR_C7 + (p * t2) / Q30_ONE;
      p  = TAYLOR_C5 + (p * t2) / Q30_ONE;
      p  = TAYLOR_C3 + (p * t2) / Q30_ONE;
      p  = TAYLOR_C1 + (p * t2) / Q30_ONE;
      v  = (p * t) / Q30_ONE;
      if (v < 0) begin
        v = 0;
      end
      v = (v + HALF_LSB) / Q15_SCALE;
      if (v > Q15_MAX) begin
        v = Q15_MAX;
      end
      tab[i] = 15'(v);
    end
    return tab;
  endfunction

endpackage

[design/qps_if.sv]
interface qps_in_if;
  import qps_pkg::*;
  logic     valid;
  logic     ready;
  command_t command;
  sample_t  sample;
  index_t   read_index;
  modport source(output valid, command, sample, read_index, input ready);
  modport sink(input valid, command, sample, read_index, output ready);
endinterface

interface qps_out_if;
  import qps_pkg::*;
  logic       valid;
  logic       ready;
  probe_t     probe_i;
  probe_t     probe_q;
  phase_out_t phase_out;
  index_t     write_position;
  sample_t    read_data;
  modport source(output valid, probe_i, probe_q, phase_out, write_position, read_data,
                 input ready);
  modport sink(input valid, probe_i, probe_q, phase_out, write_position, read_data,
               output ready);
endinterface

interface qps_cfg_if;
  import qps_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[design/quadrature_probe_scope.sv]
// channel   modport  handshake       payload
// in_ch     sink     valid / ready   command, sample, read_index
// out_ch    source   valid / ready   probe_i, probe_q, phase_out, write_position, read_data
// cfg_ch    sink     valid / ready   index, data (ready always high)
//
// a process item passes through phase step, quarter-wave table read, sample multiply,
// integrator update and output load
// a read item passes through scope store read and output load
// the result sits in an output register, so the next item is taken while it waits
// reset is synchronous and needs no clearing pass: a fill mark makes unwritten
// scope entries read as zero
module quadrature_probe_scope (
  input  logic      clk,
  input  logic      rst_n,
  qps_in_if.sink    in_ch,
  qps_out_if.source out_ch,
  qps_cfg_if.sink   cfg_ch
);
  import qps_pkg::*;

  qps_cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  qps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .cmd        (cmd)
  );

  qps_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_command         (in_ch.command),
    .in_sample          (in_ch.sample),
    .in_read_index      (in_ch.read_index),
    .cfg_valid          (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_probe_i        (out_ch.probe_i),
    .out_probe_q        (out_ch.probe_q),
    .out_phase_out      (out_ch.phase_out),
    .out_write_position (out_ch.write_position),
    .out_read_data      (out_ch.read_data)
  );

endmodule

[design/qps_ctrl.sv]
module qps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  qps_pkg::command_t in_command,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output qps_pkg::qps_cmd_t cmd
);
  import qps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_LOOK,
    S_MUL,
    S_LEAK,
    S_READ,
    S_FIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign load      = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    cmd           = '0;
    cmd.take      = in_ready && in_valid;
    cmd.advance   = (state_r == S_PHASE);
    cmd.multiply  = (state_r == S_MUL);
    cmd.integrate = (state_r == S_LEAK);
    cmd.load      = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= (in_command == CMD_READ) ? S_READ : S_PHASE;
          end
        end
        S_PHASE: state_r <= S_LOOK;
        S_LOOK:  state_r <= S_MUL;
        S_MUL:   state_r <= S_LEAK;
        S_LEAK:  state_r <= S_FIN;
        S_READ:  state_r <= S_FIN;
        S_FIN: begin
          if (load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[design/qps_dpath.sv]
module qps_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  qps_pkg::qps_cmd_t   cmd,
  input  qps_pkg::command_t   in_command,
  input  qps_pkg::sample_t    in_sample,
  input  qps_pkg::index_t     in_read_index,
  input  logic                cfg_valid,
  input  qps_pkg::cfg_index_t cfg_index,
  input  qps_pkg::cfg_data_t  cfg_data,
  output qps_pkg::probe_t     out_probe_i,
  output qps_pkg::probe_t     out_probe_q,
  output qps_pkg::phase_out_t out_phase_out,
  output qps_pkg::index_t     out_write_position,
  output qps_pkg::sample_t    out_read_data
);
  import qps_pkg::*;

  localparam qtab_t QUARTER_TABLE = build_quarter_table();

  // configuration
  logic [31:0] probe_step_r;
  logic [15:0] falloff_r;

  // state
  logic [PHASE_W-1:0]      phase_r;
  logic signed [ACC_W-1:0] acc_i_r;
  logic signed [ACC_W-1:0] acc_q_r;
  logic [ADDR_W-1:0]       ptr_r;
  logic                    wrapped_r;
  logic [15:0]             scope_mem [SCOPE_DEPTH];

  // item and pipeline payload
  command_t                item_cmd_r;
  sample_t                 item_sample_r;
  index_t                  item_idx_r;
  logic [15:0]             rdata_r;
  logic [14:0]             sin_rom_r;
  logic [14:0]             cos_rom_r;
  logic                    sin_peak_r;
  logic                    cos_peak_r;
  logic                    sin_neg_r;
  logic                    cos_neg_r;
  logic signed [ACC_W-1:0] prod_i_r;
  logic signed [ACC_W-1:0] prod_q_r;

  // table lookup
  logic [1:0]       quad;
  logic [IDX_W-1:0] idx;
  logic [IDX_W:0]   idx_ext;
  logic [IDX_W:0]   idx_mirror;
  logic [IDX_W:0]   sin_k;
  logic [IDX_W:0]   cos_k;

  assign quad       = phase_r[PHASE_W-1 -: 2];
  assign idx        = phase_r[PHASE_W-3 -: IDX_W];
  assign idx_ext    = {1'b0, idx};
  assign idx_mirror = (IDX_W+1)'(SINE_TABLE_DEPTH) - idx_ext;
  assign sin_k      = quad[0] ? idx_mirror : idx_ext;
  assign cos_k      = quad[0] ? idx_ext : idx_mirror;

  // multiply
  logic [14:0]             sin_mag;
  logic [14:0]             cos_mag;
  logic signed [15:0]      sin_val;
  logic signed [15:0]      cos_val;
  logic signed [ACC_W-1:0] full_i;
  logic signed [ACC_W-1:0] full_q;

  assign sin_mag = sin_peak_r ? TRIG_PEAK : sin_rom_r;
  assign cos_mag = cos_peak_r ? TRIG_PEAK : cos_rom_r;
  assign sin_val = sin_neg_r ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign cos_val = cos_neg_r ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
  assign full_i  = item_sample_r * cos_val;
  assign full_q  = item_sample_r * sin_val;

  // leaky integrators
  logic signed [ACC_W:0]      diff_i;
  logic signed [ACC_W:0]      diff_q;
  logic signed [ACC_W+17:0]   scaled_i;
  logic signed [ACC_W+17:0]   scaled_q;
  logic signed [16:0]         weight;

  assign weight   = $signed({1'b0, falloff_r});
  assign diff_i   = $signed({prod_i_r[ACC_W-1], prod_i_r}) - $signed({acc_i_r[ACC_W-1], acc_i_r});
  assign diff_q   = $signed({prod_q_r[ACC_W-1], prod_q_r}) - $signed({acc_q_r[ACC_W-1], acc_q_r});
  assign scaled_i = weight * diff_i;
  assign scaled_q = weight * diff_q;

  // scope read guard: entries never written read as zero
  logic rd_ok;

  assign rd_ok = (32'(item_idx_r) < SCOPE_DEPTH)
              && (wrapped_r || (32'(item_idx_r) < 32'(ptr_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_step_r <= PROBE_STEP_RESET;
      falloff_r    <= FALLOFF_RESET;
      phase_r      <= '0;
      acc_i_r      <= '0;
      acc_q_r      <= '0;
      ptr_r        <= '0;
      wrapped_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_PROBE_STEP: probe_step_r <= cfg_data;
          CFG_FALLOFF:    falloff_r    <= cfg_data[15:0];
          default:        probe_step_r <= probe_step_r;
        endcase
      end
      if (cmd.advance) begin
        phase_r <= phase_r + probe_step_r;
        if (ptr_r == ADDR_W'(SCOPE_DEPTH - 1)) begin
          ptr_r     <= '0;
          wrapped_r <= 1'b1;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      if (cmd.integrate) begin
        acc_i_r <= acc_i_r + scaled_i[ACC_W+15:16];
        acc_q_r <= acc_q_r + scaled_q[ACC_W+15:16];
      end
    end
  end

  // scope store and quarter-wave table
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      scope_mem[ptr_r] <= item_sample_r;
    end
    rdata_r    <= scope_mem[ADDR_W'(item_idx_r)];
    sin_rom_r  <= QUARTER_TABLE[sin_k[IDX_W-1:0]];
    cos_rom_r  <= QUARTER_TABLE[cos_k[IDX_W-1:0]];
    sin_peak_r <= sin_k[IDX_W];
    cos_peak_r <= cos_k[IDX_W];
    sin_neg_r  <= quad[1];
    cos_neg_r  <= quad[1] ^ quad[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_cmd_r    <= in_command;
      item_sample_r <= in_sample;
      item_idx_r    <= in_read_index;
    end
    if (cmd.multiply) begin
      prod_i_r <= {full_i[ACC_W-2:0], 1'b0};
      prod_q_r <= {full_q[ACC_W-2:0], 1'b0};
    end
    if (cmd.load) begin
      out_probe_i        <= acc_i_r[ACC_W-1 -: 16];
      out_probe_q        <= acc_q_r[ACC_W-1 -: 16];
      out_phase_out      <= phase_r[PHASE_W-1 -: 16];
      out_write_position <= 14'(ptr_r);
      out_read_data      <= ((item_cmd_r == CMD_READ) && rd_ok) ? rdata_r : '0;
    end
  end

endmodule

[test/qps_checker.sv]
module qps_checker (
  input  logic clk,
  input  logic rst_n,
  qps_in_if    in_ch,
  qps_out_if   out_ch,
  qps_cfg_if   cfg_ch,
  output int   mismatch_count,
  output int   outstanding
);
  import qps_pkg::*;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint POLY_K1 = 64'sd1686629713;
  localparam longint POLY_K3 = -64'sd693598669;
  localparam longint POLY_K5 = 64'sd85569306;
  localparam longint POLY_K7 = -64'sd5026995;
  localparam longint POLY_K9 = 64'sd172272;
  localparam int     MAX_REPORTS = 10;

  typedef struct packed {
    probe_t     probe_i;
    probe_t     probe_q;
    phase_out_t phase_out;
    index_t     write_position;
    sample_t    read_data;
  } probe_result_t;

  logic [31:0]   step_reg;
  logic [15:0]   weight_reg;
  logic [31:0]   phase_acc;
  int            acc_i;
  int            acc_q;
  index_t        wr_ptr;
  logic [15:0]   scope_mem [SCOPE_DEPTH];
  int            sine_quarter [SINE_TABLE_DEPTH];
  probe_result_t predicted_q [$];
  int            result_count;

  initial begin
    longint t;
    longint t2;
    longint p;
    longint v;
    mismatch_count = 0;
    outstanding    = 0;
    result_count   = 0;
    for (int n = 0; n < SINE_TABLE_DEPTH; n++) begin
      t  = (longint'(n) * ONE_Q30) / SINE_TABLE_DEPTH;
      t2 = (t * t) / ONE_Q30;
      p  = POLY_K9;
      p  = POLY_K7 + (p * t2) / ONE_Q30;
      p  = POLY_K5 + (p * t2) / ONE_Q30;
      p  = POLY_K3 + (p * t2) / ONE_Q30;
      p  = POLY_K1 + (p * t2) / ONE_Q30;
      v  = (p * t) / ONE_Q30;
      if (v < 0) begin
        v = 0;
      end
      v = (v + 64'sd16384) / 64'sd32768;
      if (v > 64'sd32767) begin
        v = 64'sd32767;
      end
      sine_quarter[n] = int'(v);
    end
  end

  function automatic int signed_sine(logic [31:0] ph);
    logic [IDX_W-1:0] idx;
    int               k;
    int               v;
    idx = ph[29 -: IDX_W];
    k   = ph[30] ? SINE_TABLE_DEPTH - int'(idx) : int'(idx);
    v   = (k >= SINE_TABLE_DEPTH) ? 32767 : sine_quarter[k];
    return ph[31] ? -v : v;
  endfunction

  function automatic int leak_toward(int acc, longint target);
    longint diff;
    longint delta;
    diff  = target - longint'(acc);
    delta = (longint'(weight_reg) * diff) >>> 16;
    return int'(longint'(acc) + delta);
  endfunction

  function automatic probe_result_t demod_predict(command_t cmd, sample_t smp, index_t ridx);
    probe_result_t r;
    longint        prod_i;
    longint        prod_q;
    r.read_data = '0;
    if (cmd == CMD_PROCESS) begin
      phase_acc = phase_acc + step_reg;
      prod_i = longint'(smp) * longint'(signed_sine(phase_acc + 32'h4000_0000)) * 2;
      prod_q = longint'(smp) * longint'(signed_sine(phase_acc)) * 2;
      acc_i  = leak_toward(acc_i, prod_i);
      acc_q  = leak_toward(acc_q, prod_q);
      scope_mem[wr_ptr] = smp;
      wr_ptr = wr_ptr + 1'b1;
    end else begin
      r.read_data = scope_mem[ridx];
    end
    r.probe_i        = acc_i[31:16];
    r.probe_q        = acc_q[31:16];
    r.phase_out      = phase_acc[31:16];
    r.write_position = wr_ptr;
    return r;
  endfunction

  always @(posedge clk) begin
    probe_result_t got;
    probe_result_t want;
    if (!rst_n) begin
      step_reg   = PROBE_STEP_RESET;
      weight_reg = FALLOFF_RESET;
      phase_acc  = '0;
      acc_i      = 0;
      acc_q      = 0;
      wr_ptr     = '0;
      foreach (scope_mem[n]) begin
        scope_mem[n] = '0;
      end
      predicted_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.probe_i        = out_ch.probe_i;
        got.probe_q        = out_ch.probe_q;
        got.phase_out      = out_ch.phase_out;
        got.write_position = out_ch.write_position;
        got.read_data      = out_ch.read_data;
        if (predicted_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d arrived with no prediction waiting", result_count);
          end
        end else begin
          want = predicted_q.pop_front();
          if (got.probe_i !== want.probe_i || got.probe_q !== want.probe_q ||
              got.phase_out !== want.phase_out ||
              got.write_position !== want.write_position ||
              got.read_data !== want.read_data) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("result %0d: expected i=%h q=%h phase=%h wpos=%h rdata=%h", result_count,
                       want.probe_i, want.probe_q, want.phase_out, want.write_position,
                       want.read_data);
              $display("result %0d: actual   i=%h q=%h phase=%h wpos=%h rdata=%h", result_count,
                       got.probe_i, got.probe_q, got.phase_out, got.write_position,
                       got.read_data);
            end
          end
        end
        result_count++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_PROBE_STEP: step_reg = cfg_ch.data;
          CFG_FALLOFF:    weight_reg = cfg_ch.data[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_q = {predicted_q,
                       demod_predict(in_ch.command, in_ch.sample, in_ch.read_index)};
      end
    end
    outstanding <= predicted_q.size();
  end

endmodule

[test/tb_quadrature_probe_scope.sv]
module tb_quadrature_probe_scope;
  import qps_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 12;

  logic   clk;
  logic   rst_n;
  int     mismatch_count;
  int     outstanding;
  int     burst_left;
  int     idle_cycles;
  index_t fill_pos;
  int     filled;

  qps_in_if  in_ch ();
  qps_out_if out_ch ();
  qps_cfg_if cfg_ch ();

  quadrature_probe_scope dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  qps_checker demod_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: runs of ready broken by short or long stalls
  initial begin
    int run_left;
    int stall_left;
    run_left     = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0 && stall_left == 0) begin
        run_left   = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 80);
        stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end
      if (run_left > 0) begin
        out_ch.ready <= 1'b1;
        run_left--;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(command_t cmd, sample_t smp, index_t ridx);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        @(negedge clk);
        in_ch.valid  <= 1'b0;
        in_ch.sample <= sample_t'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.sample     <= smp;
    in_ch.read_index <= ridx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd == CMD_PROCESS) begin
      fill_pos = fill_pos + 1'b1;
      filled++;
    end
  endtask

  task automatic run_random(int count, int read_pct);
    index_t  ridx;
    sample_t smp;
    int      span;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < read_pct) begin
        span = (filled < 256) ? filled : 256;
        if (span > 0 && $urandom_range(0, 3) != 0) begin
          ridx = fill_pos - index_t'(1 + $urandom_range(0, span - 1));
        end else begin
          ridx = index_t'($urandom);
        end
        send_item(CMD_READ, sample_t'($urandom), ridx);
      end else begin
        case ($urandom_range(0, 7))
          0:       smp = 16'sh7FFF;
          1:       smp = 16'sh8000;
          2:       smp = sample_t'(int'($urandom_range(0, 255)) - 128);
          default: smp = sample_t'($urandom);
        endcase
        send_item(CMD_PROCESS, smp, index_t'($urandom));
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_index_t idx, cfg_data_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(cfg_data_t step, cfg_data_t weight_word);
    drain();
    cfg_write(CFG_PROBE_STEP, step);
    cfg_write(CFG_FALLOFF, weight_word);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_PROCESS;
    in_ch.sample     = '0;
    in_ch.read_index = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_PROBE_STEP;
    cfg_ch.data      = '0;
    burst_left       = 0;
    idle_cycles      = 0;
    fill_pos         = '0;
    filled           = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: sample extremes, bit patterns, reads of written and unwritten entries
    send_item(CMD_PROCESS, 16'sh7FFF, '0);
    send_item(CMD_PROCESS, 16'sh8000, '1);
    send_item(CMD_PROCESS, 16'sh0000, '0);
    send_item(CMD_PROCESS, 16'shFFFF, '0);
    send_item(CMD_PROCESS, 16'sh5555, '0);
    send_item(CMD_PROCESS, 16'shAAAA, '0);
    send_item(CMD_PROCESS, 16'sh0001, '0);
    send_item(CMD_READ, '0, '0);
    send_item(CMD_READ, '0, fill_pos - 1'b1);
    send_item(CMD_READ, '1, '1);
    send_item(CMD_READ, '0, 14'h2AAA);
    send_item(CMD_READ, '0, 14'h1555);

    // largest step and weight
    configure(32'hFFFF_FFFF, 32'h0000_FFFF);
    send_item(CMD_PROCESS, 16'sh7FFF, '0);
    send_item(CMD_PROCESS, 16'sh8000, '0);
    send_item(CMD_PROCESS, 16'sh7FFF, '0);
    send_item(CMD_READ, '0, fill_pos - 1'b1);
    run_random(200, 30);

    // zero step and zero weight: phase and integrators hold
    configure(32'h0000_0000, 32'h0000_0000);
    send_item(CMD_PROCESS, 16'sh8000, '0);
    send_item(CMD_PROCESS, 16'sh7FFF, '0);
    run_random(150, 30);

    // quarter-cycle step, smallest nonzero weight
    configure(32'h4000_0000, 32'h0000_0001);
    run_random(150, 30);

    for (int n = 0; n < 5; n++) begin
      configure(cfg_data_t'($urandom),
                {16'($urandom), 16'($urandom_range(1, 65535))});
      run_random(200, 30);
    end

    // read-heavy traffic around the write position
    configure(cfg_data_t'($urandom), 32'h0000_1000);
    run_random(50, 60);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
